>>> hw/rtl/tfas_pkg.sv
// Shared types and constants for the tile frame animation sequencer.
// Holds the operation codes, the frame entry layout and the memory request struct.
// No dependencies.
package tfas_pkg;

    localparam int OP_W     = 2;
    localparam int TIME_W   = 16;
    localparam int SLOT_W   = 6;
    localparam int TILE_W   = 16;
    localparam int DUR_W    = 16;
    localparam int UNUSED_W = 32;
    localparam int CNT_W    = 7;
    // Frame index and memory address width; wide enough to follow any count value
    localparam int IDX_W    = CNT_W;

    typedef enum logic [OP_W-1:0] {
        OP_ADVANCE = 2'd0,
        OP_RESET   = 2'd1,
        OP_WRITE   = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BEFORE,
        S_STEP,
        S_RELOAD,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic [DUR_W-1:0]  dur;
        logic [TILE_W-1:0] tile;
    } t_entry;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
        logic [IDX_W-1:0] rd_addr;
    } t_mem_req;

endpackage

>>> hw/rtl/tfas_if.sv
// Valid/ready channel interfaces for operation items and result items.
// Depends on tfas_pkg for field widths.
interface tfas_in_if;
    logic                        valid;
    logic                        ready;
    logic [tfas_pkg::OP_W-1:0]   op;
    logic [tfas_pkg::TIME_W-1:0] elapsed_ms;
    logic [tfas_pkg::SLOT_W-1:0] frame_slot;
    logic [tfas_pkg::TILE_W-1:0] frame_tile;
    logic [tfas_pkg::DUR_W-1:0]  frame_duration;

    modport source (output valid, op, elapsed_ms, frame_slot, frame_tile, frame_duration,
                    input ready);
    modport sink   (input valid, op, elapsed_ms, frame_slot, frame_tile, frame_duration,
                    output ready);
endinterface

interface tfas_out_if;
    logic                        valid;
    logic                        ready;
    logic                        tile_changed;
    logic [tfas_pkg::TILE_W-1:0] current_tile;
    logic [tfas_pkg::SLOT_W-1:0] current_frame;

    modport source (output valid, tile_changed, current_tile, current_frame, input ready);
    modport sink   (input valid, tile_changed, current_tile, current_frame, output ready);
endinterface

>>> hw/rtl/tile_frame_animation_sequencer_unit.sv
// Tile frame animation sequencer top level: operation sequencer and result register.
// Depends on tfas_pkg, tfas_if and tfas_frame_mem.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-----------------------------------------------
//  i_in     | in  | valid/ready   | op, elapsed_ms, frame_slot, frame_tile, duration
//  o_out    | out | valid/ready   | tile_changed, current_tile, current_frame
//  cfg      | in  | i_cfg_we      | i_cfg_data = frame_count
//
// An item passes the before state, then the step state while an advance steps frames
// (else the reload state), then the final state, where the result register loads;
// each step is one read of the frame table memory. The next transfer is taken in idle.
// One item is in work at a time; the next transfer is taken once the result is
// loaded into the output register, even while that result still waits.
// Reset is synchronous, active low; the frame table is not cleared and reads of
// never written entries are undefined. A stalled output holds the sequencer in its
// final state.
module tile_frame_animation_sequencer_unit #(
    parameter int MAX_FRAMES = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    tfas_in_if.sink                  i_in,
    tfas_out_if.source               o_out,
    input  logic                     i_cfg_we,
    input  logic [tfas_pkg::CNT_W-1:0] i_cfg_data
);
    import tfas_pkg::*;

    localparam int CNT_CAP = (MAX_FRAMES > 127) ? 127 : MAX_FRAMES;

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_index, n_index;
    logic [UNUSED_W-1:0]   r_unused, n_unused;
    logic [CNT_W-1:0]      r_frame_count;
    t_op                   r_op, n_op;
    logic [TIME_W-1:0]     r_elapsed, n_elapsed;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    t_entry                r_wentry, n_wentry;
    logic [TILE_W-1:0]     r_before, n_before;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_changed, n_out_changed;
    logic [TILE_W-1:0]     r_out_tile, n_out_tile;
    logic [SLOT_W-1:0]     r_out_frame, n_out_frame;

    t_mem_req              mem_req;
    t_entry                rd_data;
    logic [CNT_W-1:0]      count;
    logic                  animated;
    logic [UNUSED_W:0]     sum;
    logic [UNUSED_W-1:0]   dur_ext;
    logic                  step;
    logic [IDX_W:0]        idx_inc;
    logic [IDX_W-1:0]      idx_next;
    logic [TILE_W-1:0]     after_tile;

    tfas_frame_mem #(
        .DEPTH(MAX_FRAMES)
    ) u_frame_mem (
        .i_clk    (i_clk),
        .i_req    (mem_req),
        .o_rd_data(rd_data)
    );

    assign count    = (r_frame_count > CNT_W'(CNT_CAP)) ? CNT_W'(CNT_CAP) : r_frame_count;
    assign animated = (count != '0);
    assign sum      = {1'b0, r_unused} + (UNUSED_W+1)'(r_elapsed);
    assign dur_ext  = UNUSED_W'(rd_data.dur);
    assign step     = (rd_data.dur != '0) && (r_unused > dur_ext);
    assign idx_inc  = {1'b0, r_index} + (IDX_W+1)'(1);
    // Wrap at the count; a stale index past the count wraps too
    assign idx_next = (idx_inc >= {1'b0, count}) ? '0 : idx_inc[IDX_W-1:0];
    assign after_tile = animated ? rd_data.tile : '0;

    always_comb begin
        n_state       = r_state;
        n_index       = r_index;
        n_unused      = r_unused;
        n_op          = r_op;
        n_elapsed     = r_elapsed;
        n_slot        = r_slot;
        n_wentry      = r_wentry;
        n_before      = r_before;
        n_out_valid   = r_out_valid;
        n_out_changed = r_out_changed;
        n_out_tile    = r_out_tile;
        n_out_frame   = r_out_frame;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = IDX_W'(r_slot);
        mem_req.wr_data = r_wentry;
        mem_req.rd_addr = r_index;
        i_in.ready    = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_op          = t_op'(i_in.op);
                    n_elapsed     = i_in.elapsed_ms;
                    n_slot        = i_in.frame_slot;
                    n_wentry.tile = i_in.frame_tile;
                    n_wentry.dur  = i_in.frame_duration;
                    n_state       = S_BEFORE;
                end
            end
            S_BEFORE: begin
                // Read data is the current frame before the operation
                n_before = rd_data.tile;
                n_state  = S_RELOAD;
                case (r_op) inside
                    OP_ADVANCE: begin
                        if (animated) begin
                            n_unused = sum[UNUSED_W] ? '1 : sum[UNUSED_W-1:0];
                            n_state  = S_STEP;
                        end
                    end
                    OP_RESET, OP_WRITE: begin
                        if (animated) begin
                            n_index  = '0;
                            n_unused = '0;
                        end
                        if (r_op == OP_WRITE && 32'(r_slot) < MAX_FRAMES) begin
                            mem_req.wr_en = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_STEP: begin
                if (step) begin
                    // Advance one frame and fetch it for the next compare
                    n_unused        = r_unused - dur_ext;
                    n_index         = idx_next;
                    mem_req.rd_addr = idx_next;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_RELOAD: begin
                n_state = S_FINAL;
            end
            S_FINAL: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_changed = animated && (r_op != OP_NONE) && (after_tile != r_before);
                    n_out_tile    = after_tile;
                    n_out_frame   = r_index[SLOT_W-1:0];
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_index       <= '0;
            r_unused      <= '0;
            r_frame_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_index     <= n_index;
            r_unused    <= n_unused;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_frame_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_elapsed     <= n_elapsed;
        r_slot        <= n_slot;
        r_wentry      <= n_wentry;
        r_before      <= n_before;
        r_out_changed <= n_out_changed;
        r_out_tile    <= n_out_tile;
        r_out_frame   <= n_out_frame;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.tile_changed  = r_out_changed;
    assign o_out.current_tile  = r_out_tile;
    assign o_out.current_frame = r_out_frame;

    // After an advance settles, leftover time never exceeds a nonzero duration
    a_step_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FINAL && r_op == OP_ADVANCE && animated && rd_data.dur != '0
        |-> r_unused <= dur_ext)
        else $error("advance ended with unused time above frame duration");

    // Reset and write operations leave frame 0 with no unused time when animated
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FINAL && (r_op == OP_RESET || r_op == OP_WRITE) && animated
        |-> r_index == '0 && r_unused == '0)
        else $error("restart did not clear index and unused time");

    // Without animation nothing moves
    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BEFORE && !animated |=> $stable(r_index) && $stable(r_unused))
        else $error("index or unused time moved while not animated");

    // Table writes come only from a frame write operation
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.wr_en |-> r_state == S_BEFORE && r_op == OP_WRITE)
        else $error("frame table written outside a frame write");

endmodule

>>> hw/rtl/tfas_frame_mem.sv
// Frame table memory: one write port, one read port, registered read data.
// Depends on tfas_pkg for the entry layout and request struct.
module tfas_frame_mem #(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  tfas_pkg::t_mem_req i_req,
    output tfas_pkg::t_entry   o_rd_data
);
    import tfas_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[AW'(i_req.wr_addr)] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[AW'(i_req.rd_addr)];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> tb/sv/tb_tile_frame_animation_sequencer_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for the tile frame animation sequencer: directed script, held
// frame run and randomized phases, each result checked against a typed expectation or an in-bench predictor.
// Depends on tfas_pkg, tfas_if and the tile_frame_animation_sequencer_unit RTL.
module tb_tile_frame_animation_sequencer_unit;
    import tfas_pkg::*;

    localparam int          MAX_FRAMES    = 64;
    localparam int          KEEP_COUNT    = -1;
    localparam int          SCRIPT_ROWS   = 25;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          DRAIN_CYCLES  = 16;
    localparam int          HOLD_ADVANCES = 60;
    localparam int          PHASES        = 9;
    localparam int          PHASE_ITEMS   = 135;
    localparam int          REPORT_LIMIT  = 10;
    localparam int          IDLE_PCT      = 16;
    localparam logic [31:0] UNUSED_MAX    = 32'hFFFF_FFFF;

    typedef struct packed {
        t_op               op;
        logic [TIME_W-1:0] elapsed_ms;
        logic [SLOT_W-1:0] frame_slot;
        logic [TILE_W-1:0] frame_tile;
        logic [DUR_W-1:0]  frame_duration;
    } op_item_t;

    typedef struct packed {
        logic              tile_changed;
        logic [TILE_W-1:0] current_tile;
        logic [SLOT_W-1:0] current_frame;
    } frame_view_t;

    typedef struct {
        int          count;
        op_item_t    item;
        bit          typed;
        frame_view_t view;
    } script_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_data;

    tfas_in_if  in_if ();
    tfas_out_if out_if ();

    tile_frame_animation_sequencer_unit #(
        .MAX_FRAMES (MAX_FRAMES)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    // Predictor state
    t_entry            frame_tbl [MAX_FRAMES];
    int unsigned       frame_pos;
    logic [31:0]       spare_ms;
    logic [CNT_W-1:0]  n_frames;

    frame_view_t       expected_views [$];
    int                mismatches = 0;
    bit                steady_flow;
    longint unsigned   cycle_count = 0;
    longint unsigned   cycle_budget;
    script_row_t       script [SCRIPT_ROWS];
    int unsigned       phase_counts [PHASES];

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic frame_view_t next_view(input op_item_t it, output int unsigned steps);
        int unsigned       span;
        logic [TILE_W-1:0] tile_before;
        logic [TILE_W-1:0] tile_after;
        frame_view_t       v;
        span        = (n_frames > MAX_FRAMES) ? MAX_FRAMES : n_frames;
        steps       = 0;
        tile_before = frame_tbl[frame_pos].tile;
        case (it.op)
            OP_ADVANCE: begin
                if (span != 0) begin
                    if (spare_ms > UNUSED_MAX - it.elapsed_ms) spare_ms = UNUSED_MAX;
                    else spare_ms = spare_ms + it.elapsed_ms;
                    // a zero duration holds the frame no matter how much time piles up
                    while (frame_tbl[frame_pos].dur != 0 &&
                           spare_ms > frame_tbl[frame_pos].dur) begin
                        spare_ms  = spare_ms - frame_tbl[frame_pos].dur;
                        frame_pos = (frame_pos + 1 >= span) ? 0 : frame_pos + 1;
                        steps++;
                    end
                end
            end
            OP_RESET, OP_WRITE: begin
                if (span != 0) begin
                    frame_pos = 0;
                    spare_ms  = '0;
                end
                if (it.op == OP_WRITE) begin
                    frame_tbl[it.frame_slot].tile = it.frame_tile;
                    frame_tbl[it.frame_slot].dur  = it.frame_duration;
                end
            end
            default: ;
        endcase
        tile_after      = frame_tbl[frame_pos].tile;
        v.tile_changed  = (span != 0) && (it.op != OP_NONE) && (tile_after != tile_before);
        v.current_tile  = (span != 0) ? tile_after : '0;
        v.current_frame = frame_pos[SLOT_W-1:0];
        return v;
    endfunction

    function automatic logic [TIME_W-1:0] pick_elapsed();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) return TIME_W'($urandom_range(0, 511));
        if (pick < 95) return TIME_W'($urandom_range(0, 4095));
        return TIME_W'($urandom());
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return '0;
        if (pick < 15) return DUR_W'($urandom());
        return DUR_W'($urandom_range(1, 255));
    endfunction

    function automatic op_item_t random_item();
        op_item_t    it;
        int unsigned pick;
        int unsigned span;
        span = (n_frames > MAX_FRAMES) ? MAX_FRAMES : n_frames;
        pick = $urandom_range(0, 99);
        if (pick < 62) it.op = OP_ADVANCE;
        else if (pick < 72) it.op = OP_RESET;
        else if (pick < 93) it.op = OP_WRITE;
        else it.op = OP_NONE;
        it.elapsed_ms = pick_elapsed();
        // aim most writes at frames in use
        if (span != 0 && $urandom_range(0, 3) != 0)
            it.frame_slot = SLOT_W'($urandom_range(0, span - 1));
        else
            it.frame_slot = SLOT_W'($urandom());
        it.frame_tile     = TILE_W'($urandom());
        it.frame_duration = pick_duration();
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer with valid held.
    task automatic send_op(input op_item_t it, input bit typed, input frame_view_t typed_view);
        frame_view_t predicted;
        int unsigned steps;
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid          <= 1'b1;
        in_if.op             <= it.op;
        in_if.elapsed_ms     <= it.elapsed_ms;
        in_if.frame_slot     <= it.frame_slot;
        in_if.frame_tile     <= it.frame_tile;
        in_if.frame_duration <= it.frame_duration;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        predicted = next_view(it, steps);
        expected_views.push_back(typed ? typed_view : predicted);
        cycle_budget += 4 * (steps + 40);
        @(negedge clk);
    endtask

    // Drain the block before touching the register.
    task automatic load_frame_count(input logic [CNT_W-1:0] value);
        in_if.valid <= 1'b0;
        while (expected_views.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        n_frames  = value;
    endtask

    always @(negedge clk) begin
        out_if.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge clk) begin : check_results
        frame_view_t want;
        frame_view_t got;
        if (rst_n && out_if.valid && out_if.ready) begin
            got = '{out_if.tile_changed, out_if.current_tile, out_if.current_frame};
            if (expected_views.size() == 0) begin
                if (mismatches < REPORT_LIMIT)
                    $display("unexpected result: changed=%0d tile=%h frame=%0d",
                             got.tile_changed, got.current_tile, got.current_frame);
                mismatches++;
            end else begin
                want = expected_views.pop_front();
                if (got !== want) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("mismatch: expected %0d/%h/%0d, got %0d/%h/%0d",
                                 want.tile_changed, want.current_tile, want.current_frame,
                                 got.tile_changed, got.current_tile, got.current_frame);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        @(posedge clk);
        while (cycle_count <= cycle_budget) @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        op_item_t hold_item;
        cycle_budget         = 20000;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_data             = '0;
        in_if.valid          = 1'b0;
        in_if.op             = OP_ADVANCE;
        in_if.elapsed_ms     = '0;
        in_if.frame_slot     = '0;
        in_if.frame_tile     = '0;
        in_if.frame_duration = '0;
        steady_flow          = 1'b0;
        frame_pos            = 0;
        spare_ms             = '0;
        n_frames             = '0;
        foreach (frame_tbl[i]) frame_tbl[i] = '0;

        script = '{
            // not animated: nothing moves, tile reads as zero
            '{0,          '{OP_WRITE,   16'h0000, 6'd0,  16'h0000, 16'h0000}, 1, '{1'b0, 16'h0000, 6'd0}},
            '{KEEP_COUNT, '{OP_ADVANCE, 16'hFFFF, 6'd0,  16'h0000, 16'h0000}, 1, '{1'b0, 16'h0000, 6'd0}},
            '{KEEP_COUNT, '{OP_NONE,    16'hFFFF, 6'd63, 16'hFFFF, 16'hFFFF}, 1, '{1'b0, 16'h0000, 6'd0}},
            // frame write compares the old tile with the new frame 0
            '{4,          '{OP_WRITE,   16'h0000, 6'd0,  16'hFFFF, 16'h0001}, 1, '{1'b1, 16'hFFFF, 6'd0}},
            '{KEEP_COUNT, '{OP_WRITE,   16'h0000, 6'd1,  16'h0001, 16'hFFFF}, 1, '{1'b0, 16'hFFFF, 6'd0}},
            '{KEEP_COUNT, '{OP_WRITE,   16'h0000, 6'd2,  16'h8000, 16'h0002}, 1, '{1'b0, 16'hFFFF, 6'd0}},
            '{KEEP_COUNT, '{OP_WRITE,   16'h0000, 6'd3,  16'h1234, 16'h0000}, 1, '{1'b0, 16'hFFFF, 6'd0}},
            // time equal to the duration does not step
            '{KEEP_COUNT, '{OP_ADVANCE, 16'h0001, 6'd0,  16'h0000, 16'h0000}, 1, '{1'b0, 16'hFFFF, 6'd0}},
            '{KEEP_COUNT, '{OP_ADVANCE, 16'h0001, 6'd0,  16'h0000, 16'h0000}, 1, '{1'b1, 16'h0001, 6'd1}},
            '{KEEP_COUNT, '{OP_ADVANCE, 16'hFFFF, 6'd0,  16'h0000, 16'h0000}, 1, '{1'b1, 16'h8000, 6'd2}},
            '{KEEP_COUNT, '{OP_ADVANCE, 16'h0002, 6'd0,  16'h0000, 16'h0000}, 1, '{1'b1, 16'h1234, 6'd3}},
            // zero duration holds
            '{KEEP_COUNT, '{OP_ADVANCE, 16'hFFFF, 6'd0,  16'h0000, 16'h0000}, 1, '{1'b0, 16'h1234, 6'd3}},
            '{KEEP_COUNT, '{OP_NONE,    16'h0000, 6'd0,  16'h0000, 16'h0000}, 1, '{1'b0, 16'h1234, 6'd3}},
            '{KEEP_COUNT, '{OP_RESET,   16'h0000, 6'd0,  16'h0000, 16'h0000}, 1, '{1'b1, 16'hFFFF, 6'd0}},
            '{KEEP_COUNT, '{OP_ADVANCE, 16'h0002, 6'd0,  16'h0000, 16'h0000}, 1, '{1'b1, 16'h0001, 6'd1}},
            '{KEEP_COUNT, '{OP_ADVANCE, 16'hFFFF, 6'd0,  16'h0000, 16'h0000}, 1, '{1'b1, 16'h8000, 6'd2}},
            // stale index past a shrunken count wraps to frame 0
            '{2,          '{OP_ADVANCE, 16'h0002, 6'd0,  16'h0000, 16'h0000}, 1, '{1'b1, 16'hFFFF, 6'd0}},
            '{1,          '{OP_ADVANCE, 16'h0005, 6'd0,  16'h0000, 16'h0000}, 1, '{1'b0, 16'hFFFF, 6'd0}},
            // count above the table acts as a full table
            '{127,        '{OP_RESET,   16'h0000, 6'd0,  16'h0000, 16'h0000}, 1, '{1'b0, 16'hFFFF, 6'd0}},
            '{KEEP_COUNT, '{OP_ADVANCE, 16'hFFFF, 6'd0,  16'h0000, 16'h0000}, 0, '0},
            '{KEEP_COUNT, '{OP_WRITE,   16'h0000, 6'd63, 16'hA5A5, 16'h8000}, 0, '0},
            '{64,         '{OP_ADVANCE, 16'hFFFF, 6'd0,  16'h0000, 16'h0000}, 0, '0},
            '{0,          '{OP_ADVANCE, 16'h0000, 6'd0,  16'h0000, 16'h0000}, 0, '0},
            '{KEEP_COUNT, '{OP_WRITE,   16'h0000, 6'd5,  16'h5A5A, 16'hFFFF}, 0, '0},
            '{64,         '{OP_RESET,   16'h0000, 6'd0,  16'h0000, 16'h0000}, 0, '0}
        };

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Fill every table entry while not animated so no read ever hits an unwritten entry.
        for (int slot = 0; slot < MAX_FRAMES; slot++) begin
            hold_item = '{OP_WRITE, pick_elapsed(), SLOT_W'(slot), TILE_W'($urandom()),
                          pick_duration()};
            send_op(hold_item, 1'b0, '0);
        end

        foreach (script[i]) begin
            if (script[i].count != KEEP_COUNT) load_frame_count(CNT_W'(script[i].count));
            send_op(script[i].item, script[i].typed, script[i].view);
        end

        // Pile time onto a held frame, then release it without a reset.
        steady_flow = 1'b1;
        load_frame_count(2);
        send_op('{OP_WRITE, 16'h0000, 6'd0, 16'h0F0F, 16'h0000}, 1'b0, '0);
        send_op('{OP_WRITE, 16'h0000, 6'd1, 16'hF0F0, 16'h9C40}, 1'b0, '0);
        send_op('{OP_RESET, 16'h0000, 6'd0, 16'h0000, 16'h0000}, 1'b0, '0);
        hold_item = '{OP_ADVANCE, 16'hFFFF, 6'd0, 16'h0000, 16'h0000};
        repeat (HOLD_ADVANCES) send_op(hold_item, 1'b0, '0);
        steady_flow = 1'b0;
        load_frame_count(0);
        send_op('{OP_WRITE, 16'h0000, 6'd0, 16'h0F0F, 16'hFFFF}, 1'b0, '0);
        load_frame_count(2);
        send_op('{OP_ADVANCE, 16'h0000, 6'd0, 16'h0000, 16'h0000}, 1'b0, '0);
        send_op('{OP_RESET, 16'h0000, 6'd0, 16'h0000, 16'h0000}, 1'b0, '0);

        phase_counts = '{64, 1, 0, 127, 3, 0, 0, 17, 64};
        phase_counts[5] = $urandom_range(2, 63);
        phase_counts[6] = $urandom_range(65, 127);
        foreach (phase_counts[p]) begin
            load_frame_count(CNT_W'(phase_counts[p]));
            steady_flow = (p == 4);
            repeat (PHASE_ITEMS) send_op(random_item(), 1'b0, '0);
        end
        steady_flow = 1'b0;

        in_if.valid <= 1'b0;
        while (expected_views.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_views.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> tile_frame_animation_sequencer_unit.f
hw/rtl/tfas_pkg.sv
hw/rtl/tfas_if.sv
hw/rtl/tfas_frame_mem.sv
hw/rtl/tile_frame_animation_sequencer_unit.sv
tb/sv/tb_tile_frame_animation_sequencer_unit.sv
